// ===== hdl/sha256_stream_hasher_unit_defines.svh =====
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose right side is checked in the cycle after the left side holds
`define SHA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== hdl/sha_pkg.sv =====
// shared constants and round functions for the sha-256 stream hasher
package sha_pkg;

   localparam int BlockBytes = 64;
   localparam int Rounds     = 64;
   localparam int CountBits  = 61;

   typedef logic [31:0] word_type;

   localparam word_type InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;

   typedef struct packed {
      logic start;   // pulse: compress the buffered block
   } comp_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;    // pulse: chaining words updated
   } comp_sts_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type ssig0(input word_type x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(input word_type x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ===== hdl/sha256_stream_hasher_unit.sv =====
// top level of the streaming sha-256 hasher
// channel | dir | beat
// req_    | in  | data_byte, byte_present, end_of_message
// rsp_    | out | digest_word, word_index, last_word
// a byte beat is written into the block buffer; the word memory write rides along with the fourth byte
// a beat that completes a block stalls the request side while the engine loads
//   the 16 block words, runs its 64 rounds and pulses done
// end of message pads one byte per cycle, held while a block compresses, then eight response beats
// reset is synchronous and returns the chaining words to the initial values
// the response beat holds while rsp_ready is low; req_ready is low meanwhile
module sha256_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StComp = 3'd1;
   localparam logic [2:0] StPad  = 3'd2;
   localparam logic [2:0] StOut  = 3'd3;

   logic [2:0]  st_ff, st_in;
   logic [5:0]  fill_ff;
   logic [CountBits-1:0] cnt_ff;
   logic [23:0] acc_ff;       // first three bytes of the current word
   logic        pad_ff;       // padding run in progress
   logic        len_ff;       // length bytes reached
   logic [2:0]  oidx_ff;
   logic        wr_en;
   word_type    wr_data;
   logic [7:0]  byte_in;
   logic        put;
   logic        want_end_ff;
   comp_ctl_type ctl;
   comp_sts_type sts;
   word_type    h_rd;
   logic [63:0] bits;

   assign bits = {cnt_ff, 3'b000};

   sha_compress u_comp (
      .clock(clock), .reset(reset), .ctl(ctl),
      .wr_en(wr_en), .wr_addr(fill_ff[5:2]), .wr_data(wr_data),
      .init_h(st_ff == StOut && rsp_ready && oidx_ff == 3'd7),
      .h_rd_idx(oidx_ff), .h_rd_data(h_rd), .sts(sts)
   );

   // next byte into the buffer
   always_comb begin
      put     = 1'b0;
      byte_in = req_data_byte;
      if (st_ff == StIdle) begin
         put = req_valid && req_byte_present;
      end else if (st_ff == StPad) begin
         put = 1'b1;
         if (!pad_ff) byte_in = PadByte;
         else if (len_ff) byte_in = bits[8*(7 - fill_ff[2:0]) +: 8];
         else byte_in = 8'h00;
      end
   end

   assign wr_en   = put && fill_ff[1:0] == 2'd3;
   assign wr_data = {acc_ff, byte_in};
   assign req_ready = st_ff == StIdle;
   assign ctl.start = put && fill_ff == 6'd63;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         StIdle: if (req_valid) begin
            if (ctl.start) st_in = StComp;
            else if (req_end_of_message) st_in = StPad;
         end
         // compress finished: resume padding, stream the digest after the final block, or return to idle
         StComp: if (sts.done) st_in = want_end_ff ? StPad : (pad_ff ? StOut : StIdle);
         StPad: if (ctl.start) st_in = StComp;
         StOut: if (rsp_ready && oidx_ff == 3'd7) st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (put) acc_ff <= {acc_ff[15:0], byte_in};
      if (reset) begin
         st_ff <= StIdle; fill_ff <= '0; cnt_ff <= '0;
         pad_ff <= 1'b0; len_ff <= 1'b0; oidx_ff <= '0; want_end_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (put) fill_ff <= fill_ff + 6'd1;
         if (st_ff == StIdle && req_valid) begin
            if (req_byte_present) cnt_ff <= cnt_ff + CountBits'(1);
            want_end_ff <= req_end_of_message;
         end
         if (st_ff == StPad) begin
            pad_ff <= 1'b1;
            if (fill_ff == LenOffset - 6'd1 && pad_ff && !len_ff) len_ff <= 1'b1;
            if (!pad_ff && fill_ff == LenOffset - 6'd1) len_ff <= 1'b1;
            if (len_ff && fill_ff == 6'd63) begin
               want_end_ff <= 1'b0;   // final block underway
               len_ff <= 1'b0;
            end
         end
         if (st_ff == StComp && sts.done && want_end_ff == 1'b0 && pad_ff) oidx_ff <= '0;
         if (st_ff == StOut && rsp_ready) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               pad_ff <= 1'b0; cnt_ff <= '0; fill_ff <= '0;
            end
         end
      end
   end

   assign rsp_valid       = st_ff == StOut;
   assign rsp_digest_word = h_rd;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = oidx_ff == 3'd7;

endmodule

// ===== hdl/sha_compress.sv =====
// sha-256 compression engine: block in a word memory, one round per cycle
module sha_compress (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::comp_ctl_type ctl,
   input  logic                  wr_en,
   input  logic [3:0]            wr_addr,
   input  sha_pkg::word_type     wr_data,
   input  logic                  init_h,
   input  logic [2:0]            h_rd_idx,
   output sha_pkg::word_type     h_rd_data,
   output sha_pkg::comp_sts_type sts
);
   import sha_pkg::*;

   // block word memory, 16 words; read at one address registered
   word_type  w_mem [16];
   word_type  w_rd_ff;
   word_type  h_ff [8];
   word_type  v_ff [8];
   word_type  v_in [8];
   word_type  win_ff [16];
   logic      busy_ff, done_ff;
   logic [6:0] rnd_ff;
   logic       load_ff;
   word_type   w_cur, t1, t2;

   // block words enter the memory; the engine copies them to its window
   always_ff @(posedge clock) begin
      if (wr_en) w_mem[wr_addr] <= wr_data;
      w_rd_ff <= w_mem[rnd_ff[3:0]];
   end

   always_comb begin
      // past round 15 the newest schedule word sits at the top of the window
      if (rnd_ff < 7'd16) w_cur = win_ff[rnd_ff[3:0]];
      else w_cur = win_ff[15];
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + RoundK[rnd_ff[5:0]] + w_cur;
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4]; v_in[4] = v_ff[3] + t1;
      v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0]; v_in[0] = t1 + t2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         load_ff <= 1'b0;
         rnd_ff  <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
      end else begin
         done_ff <= 1'b0;
         if (init_h) for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            load_ff <= 1'b1;
            rnd_ff  <= '0;
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end else if (load_ff) begin
            // one word per cycle from the memory into the window, one behind the address
            if (rnd_ff != 7'd0) win_ff[rnd_ff[3:0] - 4'd1] <= w_rd_ff;
            if (rnd_ff == 7'd16) begin
               load_ff <= 1'b0;
               rnd_ff  <= '0;
            end else begin
               rnd_ff <= rnd_ff + 7'd1;
            end
         end else if (busy_ff) begin
            for (int i = 0; i < 8; i++) v_ff[i] <= v_in[i];
            if (rnd_ff >= 7'd15) begin
               // slide window, append next schedule word
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
               win_ff[15] <= win_ff[0] + ssig0(win_ff[1]) + win_ff[9] + ssig1(win_ff[14]);
            end
            if (rnd_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_in[i];
            end
            rnd_ff <= rnd_ff + 7'd1;
         end
      end
   end

   assign h_rd_data = h_ff[h_rd_idx];
   assign sts.busy  = busy_ff | ctl.start;
   assign sts.done  = done_ff;

endmodule

// ===== hdl/sha_checker.sv =====
// port-level checks for the sha-256 stream hasher
`include "sha256_stream_hasher_unit_defines.svh"
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   `SHA_ASSERT_IMPL(a_last_idx, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7), "last flag mismatch")
   `SHA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "request taken during digest")
   `SHA_ASSERT_NEXT(a_idx_step, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1, "digest word skipped")
endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_word_index(rsp_word_index), .rsp_last_word(rsp_last_word)
);

// ===== tb/sv/sha256_stream_hasher_unit_checker.sv =====
// digest predictor and response checker for the sha-256 stream hasher
`timescale 1ns / 100ps
module sha256_stream_hasher_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          error_count,
   output int          words_pending
);
   import sha_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   word_type        chain_h [8];
   logic [7:0]      msg_block [64];
   logic [5:0]      fill_level;
   logic [60:0]     msg_bytes;
   digest_beat_type digest_queue [$];

   function automatic word_type rr(input word_type x, input int n);
      rr = (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      word_type w [64];
      word_type v [8];
      word_type t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = chain_h[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
         t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] += v[i];
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      msg_block[fill_level] = b;
      fill_level = fill_level + 6'd1;
      if (fill_level == 6'd0) compress_block();
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain_h[i] = InitH[i];
      fill_level = '0;
      msg_bytes  = '0;
   endtask

   task automatic absorb_beat(input logic [7:0] b, input logic present, input logic eom);
      logic [63:0] bit_len;
      digest_beat_type beat;
      if (present) begin
         absorb_byte(b);
         msg_bytes = msg_bytes + 61'd1;
      end
      if (eom) begin
         bit_len = {msg_bytes, 3'b000};
         absorb_byte(PadByte);
         while (fill_level != LenOffset) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            beat.word  = chain_h[i];
            beat.index = i[2:0];
            beat.last  = (i == 7);
            digest_queue = {digest_queue, beat};
         end
         restart_message();
      end
   endtask

   assign words_pending = digest_queue.size();

   initial begin
      error_count = 0;
      restart_message();
   end

   always @(posedge clock) begin
      digest_beat_type exp_beat;
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest beat word=%h index=%0d last=%b", $time,
                        rsp_digest_word, rsp_word_index, rsp_last_word);
               error_count++;
            end else begin
               exp_beat = digest_queue.pop_front();
               if (rsp_digest_word !== exp_beat.word) begin
                  $display("%0t: digest_word expected %h actual %h", $time,
                           exp_beat.word, rsp_digest_word);
                  error_count++;
               end
               if (rsp_word_index !== exp_beat.index) begin
                  $display("%0t: word_index expected %0d actual %0d", $time,
                           exp_beat.index, rsp_word_index);
                  error_count++;
               end
               if (rsp_last_word !== exp_beat.last) begin
                  $display("%0t: last_word expected %b actual %b", $time,
                           exp_beat.last, rsp_last_word);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            absorb_beat(req_data_byte, req_byte_present, req_end_of_message);
      end
   end
endmodule

// ===== tb/sv/sha256_stream_hasher_unit_tb.sv =====
// stimulus and verdict for the sha-256 stream hasher testbench
`timescale 1ns / 100ps
module sha256_stream_hasher_unit_tb;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          error_count;
   int          words_pending;
   int          cycle_count;
   int          beats_sent;
   int          burst_left;
   int          stall_mode;

   // cycle limit: ~320 request beats with gaps, plus long messages and response
   // stalls, taken many times over
   localparam int CycleLimit = 400000;

   sha256_stream_hasher_unit dut (.*);

   sha256_stream_hasher_unit_checker checker_inst (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall pattern: mode changes now and then
   // 0 never stalls, 1 stalls at random, 2 long stretches low
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 2) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // one beat: hold valid until accepted, with a burst/gap idle scheme
   task automatic send_beat(input logic [7:0] b, input logic present, input logic eom);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         repeat (gap) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_byte_present   <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // message of given length, ended by an eom beat with or without a byte
   task automatic send_message(input int len, input logic empty_tail, input int fill_kind);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (fill_kind)
            0: b = 8'($urandom_range(0, 255));
            1: b = 8'h00;
            default: b = 8'hff;
         endcase
         send_beat(b, 1'b1, (!empty_tail && i == len - 1));
      end
      if (empty_tail || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int len;
      cycle_count        = 0;
      beats_sent         = 0;
      burst_left         = 0;
      stall_mode         = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_byte      = 8'h00;
      req_byte_present   = 1'b0;
      req_end_of_message = 1'b0;
      rsp_ready          = 1'b1;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed: empty message, idle beats, byte extremes, padding boundaries
      send_message(0, 1'b1, 0);
      send_beat(8'ha5, 1'b0, 1'b0);
      send_message(1, 1'b0, 1);
      send_message(1, 1'b0, 2);
      send_message(3, 1'b0, 0);
      send_message(2, 1'b1, 0);
      send_message(55, 1'b0, 0);
      send_message(56, 1'b0, 2);
      send_message(63, 1'b1, 0);
      send_message(64, 1'b0, 0);

      // hold off until all digests are back
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);

      // random messages, mostly short, a few spanning two or three blocks
      while (beats_sent < 320) begin
         if ($urandom_range(0, 7) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
         send_message(len, $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0 ? 2 : 0);
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
